// ----- rtl/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- rtl/bptt_pkg.sv -----
// package for the tree transform check: payload types, commands, states
// no dependencies
package bptt_pkg;
  localparam int WordBits = 128;
  localparam int PosW = 7;
  localparam int NodeW = 7;
  localparam int LenW = 8;
  localparam int StackDepth = 64;
  localparam int StackW = 6;

  typedef struct packed {
    logic [63:0] word_upper;
    logic [63:0] word_lower;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_upper;
    logic [63:0] result_lower;
    logic        is_fixed;
    logic        malformed;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MATCH, ST_BUILD, ST_CHECK, ST_DONE
  } state_t;

  // transform step within one span
  typedef enum logic [1:0] {
    BP_SPAN, BP_EMIT, BP_POP
  } bphase_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic match_step;
    logic build_init;
    logic build_step;
    logic check_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic match_done;
    logic bad;
    logic build_done;
    logic check_done;
  } sts_t;
endpackage

// ----- rtl/bptt_ctrl.sv -----
// controller sequencing match, build and check phases
// depends on bptt_pkg
module bptt_ctrl import bptt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);
  state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_fire) state_next = ST_MATCH;
      ST_MATCH: begin
        if (sts.bad) state_next = ST_DONE;
        else if (sts.match_done) state_next = ST_BUILD;
      end
      ST_BUILD: if (sts.build_done) state_next = ST_CHECK;
      ST_CHECK: if (sts.check_done) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE:  begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      ST_MATCH: begin
        cmd.match_step = 1'b1;
        cmd.build_init = sts.match_done & ~sts.bad;
      end
      ST_BUILD: cmd.build_step = 1'b1;
      ST_CHECK: cmd.check_step = 1'b1;
      ST_DONE:  done = 1'b1;
      default:  busy = 1'b0;
    endcase
  end
endmodule

// ----- rtl/bptt_dp.sv -----
// datapath: match stack, close table, work stack, result shifter, checker
// depends on bptt_pkg
module bptt_dp import bptt_pkg::*; #(
  parameter int MaxNodes = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  in_word_t         in_word,
  input  logic [NodeW-1:0] nodes,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic [127:0]     res,
  output logic             fixed,
  output logic             bad
);
  logic [127:0]    word;
  logic [LenW-1:0] len;
  logic [LenW-1:0] pos;      // scan index i
  logic            mph;      // act phase of a bit, after the pend read
  logic [LenW-1:0] top;      // opens still pending

  // pending open positions and close table as memories
  logic [PosW-1:0] pend [WordBits];
  logic [PosW-1:0] closes [WordBits];
  logic [PosW-1:0] pend_top;

  // work stack: each entry is a deferred "emit 0, then span [l,r)"
  logic [2*LenW-1:0] wstk [StackDepth];
  logic [StackW:0]   wtop;
  logic [LenW-1:0]   cur_l;
  logic [LenW-1:0]   cur_r;
  logic [PosW-1:0]   cm;       // close of cur_l, read from table
  bphase_t           bphase;
  logic [LenW-1:0]   ck;
  logic [LenW-1:0]   ck_mirror;

  logic [LenW-1:0] bidx;
  logic bit_now;
  logic m_act, m_end, m_bit, m_open, m_close, m_err;
  logic b_act, b_span_empty, b_span_node, b_emit, b_pop, b_last;
  logic c_act, c_end, c_cmp;

  assign bidx = len - 8'd1 - pos;
  assign bit_now = word[bidx[PosW-1:0]];

  // match phase handles each bit by first reading the pend top, then acting
  assign m_act   = cmd.match_step && !sts.match_done && !sts.bad;
  assign m_end   = m_act && (pos >= len);
  assign m_bit   = m_act && (pos < len) && mph;
  assign m_open  = m_bit && bit_now;
  assign m_close = m_bit && !bit_now && (top != '0);
  assign m_err   = (m_bit && !bit_now && (top == '0)) || (m_end && (top != '0));

  // build steps
  assign b_act        = cmd.build_step && !sts.build_done;
  assign b_span_empty = b_act && (bphase == BP_SPAN) && (cur_l >= cur_r);
  assign b_span_node  = b_act && (bphase == BP_SPAN) && (cur_l < cur_r);
  assign b_emit       = b_act && (bphase == BP_EMIT);
  assign b_pop        = b_act && (bphase == BP_POP) && (wtop != '0);
  assign b_last       = b_act && (bphase == BP_POP) && (wtop == '0);

  // reversed-complement check
  assign c_act     = cmd.check_step && !sts.check_done;
  assign c_end     = c_act && (ck >= len);
  assign c_cmp     = c_act && (ck < len);
  assign ck_mirror = len - 8'd1 - ck;

  // status pulses
  always_ff @(posedge clk) begin
    if (rst) sts <= '0;
    else begin
      sts.match_done <= m_end && (top == '0);
      sts.bad        <= m_err;
      sts.build_done <= b_last;
      sts.check_done <= c_end;
    end
  end

  // input word and its length
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= {in_word.word_upper, in_word.word_lower};
      len  <= (nodes > NodeW'(MaxNodes)) ? LenW'(2 * MaxNodes) : {nodes, 1'b0};
    end
  end

  // scan position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos <= '0;
      mph <= 1'b0;
    end else if (m_act && (pos < len)) begin
      mph <= !mph;
      if (mph) pos <= pos + 8'd1;
    end
  end

  // pending stack depth
  always_ff @(posedge clk) begin
    if (cmd.load) top <= '0;
    else if (m_open) top <= top + 8'd1;
    else if (m_close) top <= top - 8'd1;
  end

  // pending and close memories
  always_ff @(posedge clk) begin
    if (m_open) pend[top[PosW-1:0]] <= pos[PosW-1:0];
  end

  always_ff @(posedge clk) begin
    pend_top <= (top != '0) ? pend[PosW'(top - 8'd1)] : '0;
  end

  always_ff @(posedge clk) begin
    if (m_close) closes[pend_top] <= pos[PosW-1:0];
  end

  always_ff @(posedge clk) begin
    if (b_span_node) cm <= closes[cur_l[PosW-1:0]];
  end

  // work stack
  always_ff @(posedge clk) begin
    if (b_emit) wstk[wtop[StackW-1:0]] <= {cur_l + 8'd1, 1'b0, cm};
  end

  always_ff @(posedge clk) begin
    if (cmd.build_init) wtop <= '0;
    else if (b_emit) wtop <= wtop + 7'd1;
    else if (b_pop) wtop <= wtop - 7'd1;
  end

  // current span: right part first, deferred inner part from the stack
  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      cur_l <= '0;
      cur_r <= len;
    end else if (b_emit) begin
      cur_l <= {1'b0, cm} + 8'd1;
    end else if (b_pop) begin
      {cur_l, cur_r} <= wstk[StackW'(wtop - 7'd1)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_init) bphase <= BP_SPAN;
    else if (b_span_empty) bphase <= BP_POP;
    else if (b_span_node) bphase <= BP_EMIT;
    else if (b_emit || b_pop) bphase <= BP_SPAN;
  end

  // result shifter
  always_ff @(posedge clk) begin
    if (cmd.load) res <= '0;
    else if (b_emit) res <= {res[126:0], 1'b1};
    else if (b_pop) res <= {res[126:0], 1'b0};
  end

  // flags
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fixed <= 1'b1;
      bad   <= 1'b0;
    end else if (m_err) begin
      fixed <= 1'b0;
      bad   <= 1'b1;
    end else if (c_cmp && (res[ck[PosW-1:0]] == res[ck_mirror[PosW-1:0]])) begin
      fixed <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_init) ck <= '0;
    else if (c_cmp) ck <= ck + 8'd1;
  end
endmodule

// ----- rtl/bp_tree_transform_fixed_check.sv -----
// top level of the tree transform check
// depends on bptt_pkg, bptt_ctrl, bptt_dp, assert_macros.svh
// One word at a time: the match scan goes over the word bit by bit through the
// pending-open memory, the transform goes node by node through the work-stack
// memory, and the check goes over the result bit by bit before the result is
// valid; a malformed word finishes as soon as the scan fails.
// The block takes a new word the cycle after the previous result has been taken.
`include "assert_macros.svh"
module bp_tree_transform_fixed_check import bptt_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);
  logic [NodeW-1:0] node_total;
  cmd_t cmd;
  sts_t sts;
  logic busy, done, fixed, bad;
  logic [127:0] res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) node_total <= '0;
    else if (cfg_valid) node_total <= cfg_data;
  end

  assign in_ready = !busy && !out_valid;

  bptt_ctrl u_ctrl (
    .clk, .rst, .in_fire(in_valid && in_ready), .sts, .cmd, .busy, .done
  );

  bptt_dp #(.MaxNodes(MAX_NODES)) u_dp (
    .clk, .rst, .in_word(in_data), .nodes(node_total), .cmd, .sts, .res, .fixed, .bad
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (done) out_data <= {res[127:64], res[63:0], fixed, bad};
  end

  `ASSERT_IMPLIES(a_no_accept_busy, clk, rst, busy, !in_ready)
  `ASSERT_IMPLIES(a_bad_zero, clk, rst, out_valid && out_data.malformed, !out_data.is_fixed)
  `ASSERT_NEXT(a_done_valid, clk, rst, done, out_valid)
endmodule
